@@ sv/bgd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

	// Timer width default and configuration register width
	localparam int TIMER_BITS_DEF = 16;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_IDX_W      = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINDOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD    = 2'd2;

	// Reset values of the window registers
	localparam logic [CFG_DATA_W-1:0] CLICK_WINDOW_RST = 16'd50;
	localparam logic [CFG_DATA_W-1:0] HOLD_WINDOW_RST  = 16'd50;
	localparam logic [CFG_DATA_W-1:0] LONG_HOLD_RST    = 16'd350;

	// Gesture codes
	typedef logic [2:0] gesture_t;
	localparam gesture_t GEST_NONE       = 3'd0;
	localparam gesture_t GEST_CLICK      = 3'd1;
	localparam gesture_t GEST_DOUBLE     = 3'd2;
	localparam gesture_t GEST_HOLD       = 3'd3;
	localparam gesture_t GEST_CLICK_HOLD = 3'd4;
	localparam gesture_t GEST_LONG_HOLD  = 3'd5;

	// Window lengths as seen by the machine
	typedef struct packed {
		logic [CFG_DATA_W-1:0] click_window;
		logic [CFG_DATA_W-1:0] hold_window;
		logic [CFG_DATA_W-1:0] long_hold;
	} cfg_t;

endpackage

@@ sv/bgd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bgd_cfg_regs
// Window length registers, written by index, no read-back.
// ----------------------------------------------------------------------------
module bgd_cfg_regs import bgd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_window <= CLICK_WINDOW_RST;
			cfg_q.hold_window  <= HOLD_WINDOW_RST;
			cfg_q.long_hold    <= LONG_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLICK_WINDOW: cfg_q.click_window <= cfg_data;
				CFG_HOLD_WINDOW:  cfg_q.hold_window  <= cfg_data;
				CFG_LONG_HOLD:    cfg_q.long_hold    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/bgd_fsm.sv @@
// ----------------------------------------------------------------------------
// bgd_fsm
// Level tracker, window timer and gesture state machine; one tick per step.
// ----------------------------------------------------------------------------
module bgd_fsm import bgd_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  logic     level,
	input  cfg_t     cfg,
	output gesture_t gesture,
	output logic     level_seen
);

	localparam int LOAD_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
	localparam logic [LOAD_W-1:0] TIMER_TOP = LOAD_W'({TIMER_BITS{1'b1}});

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_CLICK1   = 7'b0000010,
		ST_PRE      = 7'b0000100,
		ST_CLICK2   = 7'b0001000,
		ST_HOLD     = 7'b0010000,
		ST_CNH      = 7'b0100000,
		ST_HOLD_REL = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_PRESS,
		EV_RELEASE,
		EV_TIMEOUT
	} event_t;

	// window load, saturated to what the timer holds
	function automatic logic [TIMER_BITS-1:0] sat_load(input logic [CFG_DATA_W-1:0] ticks);
		logic [LOAD_W-1:0] wide;
		wide = LOAD_W'(ticks);
		if (wide > TIMER_TOP)
			return TIMER_BITS'(TIMER_TOP);
		else
			return TIMER_BITS'(wide);
	endfunction

	state_t                state_q, state_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic                  last_q, last_d;
	logic                  running;
	logic                  timeout;
	event_t                ev;
	gesture_t              gest;

	assign running = (timer_q != '0);
	assign timeout = running && (timer_q == TIMER_BITS'(1));

	// event decode and machine step
	always_comb begin
		state_d = state_q;
		timer_d = running ? (timer_q - 1'b1) : '0;
		last_d  = last_q;
		gest    = GEST_NONE;
		ev      = EV_NONE;

		// a timeout tick skips the sample
		if (timeout) begin
			ev = EV_TIMEOUT;
		end else if (level != last_q) begin
			last_d = level;
			ev     = level ? EV_PRESS : EV_RELEASE;
		end

		unique case (state_q)
			ST_CLICK1: begin
				if (ev == EV_RELEASE) begin
					gest    = GEST_CLICK;
					state_d = ST_PRE;
				end else if (ev == EV_TIMEOUT) begin
					timer_d = sat_load(cfg.hold_window);
					state_d = ST_HOLD;
				end
			end
			ST_PRE: begin
				if (ev == EV_PRESS)
					state_d = ST_CLICK2;
				else if (ev == EV_TIMEOUT)
					state_d = ST_IDLE;
			end
			ST_CLICK2: begin
				if (ev == EV_RELEASE) begin
					gest    = GEST_DOUBLE;
					timer_d = '0;
					state_d = ST_IDLE;
				end else if (ev == EV_TIMEOUT) begin
					timer_d = sat_load(cfg.hold_window);
					state_d = ST_CNH;
				end
			end
			ST_HOLD, ST_CNH: begin
				if (ev == EV_RELEASE) begin
					timer_d = '0;
					state_d = ST_IDLE;
				end else if (ev == EV_TIMEOUT) begin
					gest    = (state_q == ST_HOLD) ? GEST_HOLD : GEST_CLICK_HOLD;
					timer_d = sat_load(cfg.long_hold);
					state_d = ST_HOLD_REL;
				end
			end
			ST_HOLD_REL: begin
				if (ev == EV_RELEASE) begin
					timer_d = '0;
					state_d = ST_IDLE;
				end else if (ev == EV_TIMEOUT) begin
					gest    = GEST_LONG_HOLD;
					state_d = ST_IDLE;
				end
			end
			default: begin
				// idle, and any stray code behaves as idle
				state_d = ST_IDLE;
				if (ev == EV_PRESS) begin
					timer_d = sat_load(cfg.click_window);
					state_d = ST_CLICK1;
				end
			end
		endcase
	end

	// state update, once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			timer_q <= '0;
			last_q  <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			timer_q <= timer_d;
			last_q  <= last_d;
		end
	end

	assign gesture    = gest;
	assign level_seen = last_d;

endmodule

@@ sv/button_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// button_gesture_detector
// Click, double click, hold, click-and-hold and long hold from polled samples.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata[0] button_level
// m_*      out  tvalid/tready      tdata[2:0] gesture, tdata[3] level_seen
// cfg_*    in   cfg_we             cfg_index, cfg_data (16 bits)
//
// One request per cycle sustained while m_tready is high; input register,
// then result register, with the machine and timer update in between.
// Every tick gives exactly one result, gesture none on most ticks.
// Reset returns the machine to idle, the timer stopped, level released and
// window registers to 50/50/350. No clearing pass.
// A stall on m_tready holds the result register and backs up into s_tready.
// ----------------------------------------------------------------------------
module button_gesture_detector import bgd_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] button_level
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [2:0] gesture, [3] level_seen
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t     cfg;
	logic     valid_s1;
	logic     level_s1;
	logic     out_valid_q;
	gesture_t gesture_q;
	logic     level_seen_q;
	logic     adv;
	logic     step;
	gesture_t gesture_d;
	logic     level_seen_d;

	bgd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bgd_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.level      (level_s1),
		.cfg        (cfg),
		.gesture    (gesture_d),
		.level_seen (level_seen_d)
	);

	// flow control: result register frees when empty or taken
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1 <= s_tdata[0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			gesture_q    <= gesture_d;
			level_seen_q <= level_seen_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, level_seen_q, gesture_q};

endmodule

@@ sv/bgd_checker.sv @@
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks on the result stream of the gesture detector.
// ----------------------------------------------------------------------------
module bgd_checker import bgd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// gesture code stays within the defined set
	a_gesture_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= GEST_LONG_HOLD))
		else $error("gesture code out of range");

	// padding bits are zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:4] == 4'b0000))
		else $error("result padding not zero");

	// clicks are reported on release
	a_click_released: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] == GEST_CLICK || m_tdata[2:0] == GEST_DOUBLE))
		|-> !m_tdata[3])
		else $error("click reported with button pressed");

	// hold reports come while the button is down
	a_hold_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] == GEST_HOLD || m_tdata[2:0] == GEST_CLICK_HOLD
		|| m_tdata[2:0] == GEST_LONG_HOLD)) |-> m_tdata[3])
		else $error("hold reported with button released");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed under stall");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (.*);

@@ tb/sv/tb_button_gesture_detector.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_gesture_detector
// Checks every tick result of the gesture detector against a cycle-free
// predictor of the machine, its window timer and its last seen level. Button
// levels are sent as runs around the window lengths under several window
// settings, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module tb_button_gesture_detector;
	import bgd_pkg::*;

	localparam int TMR_W      = TIMER_BITS_DEF;
	localparam int WDOG_LIMIT = 2000;
	localparam int MAX_SHOWN  = 10;

	// Register index the block must ignore
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	// Hand-picked taps for windows 4/2/3: double click, click with a press on
	// the timeout tick, hold then long hold, click and hold
	localparam string DIRECTED_TAPS = "1010100011111111111010111110";

	typedef enum logic [2:0] {
		S_IDLE, S_CLICK1, S_PRE, S_CLICK2, S_HOLD, S_CLICK_HOLD, S_HOLD_REL
	} det_state_t;

	typedef enum logic [1:0] {EV_NONE, EV_PRESS, EV_RELEASE, EV_TIMEOUT} tick_event_t;

	typedef struct packed {
		gesture_t gesture;
		logic     level_seen;
	} tick_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;   // [0] button_level
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;          // [2:0] gesture, [3] level_seen
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Predictor state
	cfg_t             win_cfg     = '{CLICK_WINDOW_RST, HOLD_WINDOW_RST, LONG_HOLD_RST};
	det_state_t       det_state   = S_IDLE;
	logic [TMR_W-1:0] win_timer   = '0;
	logic             seen_level  = 1'b0;

	logic         pending_levels[$];
	tick_result_t expected_ticks[$];

	int s_idle_pct = 0;
	int m_idle_pct = 0;
	int s_gap = 0;
	int m_gap = 0;
	int errors = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int settings_used = 1;
	int quiet_cycles = 0;
	int gest_count[8];

	tick_result_t sent_result;
	tick_result_t want;

	button_gesture_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Window load, saturated at the timer width
	function automatic logic [TMR_W-1:0] clamp_load(logic [CFG_DATA_W-1:0] ticks);
		if (TMR_W < CFG_DATA_W && ticks > {TMR_W{1'b1}})
			return {TMR_W{1'b1}};
		return ticks;
	endfunction

	// One poll tick of the detector: timer, event, machine
	function automatic tick_result_t advance_detector(logic level);
		tick_result_t r;
		tick_event_t  ev;
		r.gesture = GEST_NONE;
		ev = EV_NONE;
		if (win_timer != 0) begin
			win_timer = win_timer - 1'b1;
			if (win_timer == 0)
				ev = EV_TIMEOUT;
		end
		// a level change on a timeout tick is left for a later tick
		if (ev != EV_TIMEOUT && level != seen_level) begin
			seen_level = level;
			ev = level ? EV_PRESS : EV_RELEASE;
		end
		case (det_state)
			S_CLICK1: begin
				if (ev == EV_RELEASE) begin
					r.gesture = GEST_CLICK;
					det_state = S_PRE;
				end else if (ev == EV_TIMEOUT) begin
					win_timer = clamp_load(win_cfg.hold_window);
					det_state = S_HOLD;
				end
			end
			S_PRE: begin
				if (ev == EV_PRESS)
					det_state = S_CLICK2;
				else if (ev == EV_TIMEOUT)
					det_state = S_IDLE;
			end
			S_CLICK2: begin
				if (ev == EV_RELEASE) begin
					r.gesture = GEST_DOUBLE;
					win_timer = '0;
					det_state = S_IDLE;
				end else if (ev == EV_TIMEOUT) begin
					win_timer = clamp_load(win_cfg.hold_window);
					det_state = S_CLICK_HOLD;
				end
			end
			S_HOLD, S_CLICK_HOLD: begin
				if (ev == EV_RELEASE) begin
					win_timer = '0;
					det_state = S_IDLE;
				end else if (ev == EV_TIMEOUT) begin
					r.gesture = (det_state == S_HOLD) ? GEST_HOLD : GEST_CLICK_HOLD;
					win_timer = clamp_load(win_cfg.long_hold);
					det_state = S_HOLD_REL;
				end
			end
			S_HOLD_REL: begin
				if (ev == EV_RELEASE) begin
					win_timer = '0;
					det_state = S_IDLE;
				end else if (ev == EV_TIMEOUT) begin
					r.gesture = GEST_LONG_HOLD;
					det_state = S_IDLE;
				end
			end
			default: begin
				if (ev == EV_PRESS) begin
					win_timer = clamp_load(win_cfg.click_window);
					det_state = S_CLICK1;
				end
			end
		endcase
		r.level_seen = seen_level;
		gest_count[r.gesture]++;
		return r;
	endfunction

	task automatic note_failure(string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Driver: sends queued levels, with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				sent_result = advance_detector(s_tdata[0]);
				expected_ticks.push_back(sent_result);
				ticks_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (s_gap > 0) begin
					s_gap--;
					s_tvalid <= 1'b0;
				end else if ($urandom_range(0, 99) < s_idle_pct) begin
					s_gap = $urandom_range(0, 8);
					s_tvalid <= 1'b0;
				end else if (pending_levels.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {7'd0, pending_levels.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (expected_ticks.size() == 0) begin
					note_failure($sformatf("result %0h with nothing expected", m_tdata));
				end else begin
					want = expected_ticks.pop_front();
					if (m_tdata[2:0] !== want.gesture)
						note_failure($sformatf("tick %0d gesture exp %0d got %0d",
							results_checked, want.gesture, m_tdata[2:0]));
					if (m_tdata[3] !== want.level_seen)
						note_failure($sformatf("tick %0d level_seen exp %0b got %0b",
							results_checked, want.level_seen, m_tdata[3]));
				end
			end
			if (m_gap > 0) begin
				m_gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < m_idle_pct) begin
				m_gap = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", WDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic add_run(logic lvl, int len);
		repeat (len) pending_levels.push_back(lvl);
	endtask

	// Level runs around the window lengths, with glitches mixed in
	task automatic add_runs(int n_items, int max_run);
		int   queued;
		int   len;
		int   pick;
		logic lvl;
		queued = 0;
		lvl = 1'($urandom_range(0, 1));
		while (queued < n_items) begin
			pick = $urandom_range(0, 99);
			len = (pick < 15) ? $urandom_range(1, 2) : $urandom_range(1, max_run);
			add_run(lvl, len);
			queued += len;
			if ($urandom_range(0, 9) != 0)
				lvl = ~lvl;
		end
	endtask

	task automatic wait_drained(int settle);
		do @(negedge clk);
		while (pending_levels.size() != 0 || s_tvalid || expected_ticks.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_CLICK_WINDOW: win_cfg.click_window = val;
			CFG_HOLD_WINDOW:  win_cfg.hold_window  = val;
			CFG_LONG_HOLD:    win_cfg.long_hold    = val;
			default: ;
		endcase
	endtask

	// New window setting once the block is idle; junk index goes last
	task automatic set_windows(int click, int hold, int long_hold, int s_pct, int m_pct);
		wait_drained(4);
		write_reg(CFG_CLICK_WINDOW, CFG_DATA_W'(click));
		write_reg(CFG_HOLD_WINDOW, CFG_DATA_W'(hold));
		write_reg(CFG_LONG_HOLD, CFG_DATA_W'(long_hold));
		write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		s_idle_pct = s_pct;
		m_idle_pct = m_pct;
		settings_used++;
	endtask

	// Stimulus and end of run
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset windows: one full long hold, then random runs
		s_idle_pct = 10;
		m_idle_pct = 10;
		add_run(1'b1, 460);
		add_run(1'b0, 5);
		add_runs(80, 60);

		// short windows, directed taps
		set_windows(4, 2, 3, 15, 15);
		for (int i = 0; i < DIRECTED_TAPS.len(); i++)
			pending_levels.push_back(DIRECTED_TAPS.getc(i) == "1");

		set_windows($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
			25, 5);
		add_runs(150, 20);

		// shortest windows
		set_windows(1, 1, 1, 5, 25);
		add_runs(80, 4);

		// zero windows leave the timer stopped
		set_windows(0, 3, 0, 20, 20);
		add_runs(80, 10);
		set_windows(3, 0, 2, 0, 30);
		add_runs(80, 10);

		// widest windows, no timeout within reach
		set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 30, 0);
		add_runs(60, 30);

		// last part runs with no idling
		set_windows($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40),
			0, 0);
		add_runs(120, 60);

		wait_drained(8);
		if (expected_ticks.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_ticks.size()));

		$display("%0d ticks sent, %0d results checked, %0d window settings",
			ticks_sent, results_checked, settings_used);
		$display("gestures: click %0d, double %0d, hold %0d, click-hold %0d, long hold %0d",
			gest_count[GEST_CLICK], gest_count[GEST_DOUBLE], gest_count[GEST_HOLD],
			gest_count[GEST_CLICK_HOLD], gest_count[GEST_LONG_HOLD]);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
